/* rtl/bss_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the bounded set store.
// No dependencies; imported by the interfaces and every module of the block.
package bss_pkg;

    // Request kinds; the unused code behaves as a lookup
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    // Result codes
    localparam logic [2:0] ST_INSERTED   = 3'd0;
    localparam logic [2:0] ST_PRESENT    = 3'd1;
    localparam logic [2:0] ST_FULL       = 3'd2;
    localparam logic [2:0] ST_REMOVED    = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd4;
    localparam logic [2:0] ST_MEMBER     = 3'd5;
    localparam logic [2:0] ST_NOT_MEMBER = 3'd6;

    localparam int unsigned LIMIT_W  = 7;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned COUNT_W  = 7;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

    typedef logic [1:0]          t_mode;
    typedef logic [VALUE_W-1:0]  t_value;
    typedef logic [STATUS_W-1:0] t_status;

    // Per-cell write controls
    typedef struct packed {
        logic load;   // take the key
        logic shift;  // take the upper neighbor's value
    } t_cell_ctl;

endpackage

/* rtl/bss_if.sv */
`timescale 1ns / 1ps
// Request and response channel interfaces (valid/ready handshake).
// Depends on bss_pkg for payload types.
interface bss_req_if
    import bss_pkg::*;
();
    logic                valid;
    logic                ready;
    t_mode               mode;
    logic signed [31:0]  element_value;

    modport source (output valid, output mode, output element_value, input ready);
    modport sink   (input valid, input mode, input element_value, output ready);
endinterface

interface bss_rsp_if
    import bss_pkg::*;
();
    logic        valid;
    logic        ready;
    t_status     status;
    logic [6:0]  element_count;

    modport source (output valid, output status, output element_count, input ready);
    modport sink   (input valid, input status, input element_count, output ready);
endinterface

/* rtl/bounded_set_store.sv */
`timescale 1ns / 1ps
// Bounded set store: a row of CAPACITY cells holding distinct values in insertion order.
// A request beat passes through accept, compare in every cell, reduce match bits,
// then update cells and load the result register. One request at a time: the next is
// accepted only after the update, which waits while the result register is stalled.
// Synchronous active-low reset empties the set and sets the limit to 64; cell contents
// are not cleared, only the count marks which are live.
module bounded_set_store
    import bss_pkg::*;
#(
    parameter int unsigned CAPACITY = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    bss_req_if.sink            i_req,
    bss_rsp_if.source          o_rsp,
    input  logic               i_cfg_wr_en,
    input  logic [LIMIT_W-1:0] i_cfg_wr_data
);

    localparam int unsigned IW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned LW = (CW > LIMIT_W) ? CW : LIMIT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_RED,
        S_UPD
    } t_state;

    t_state             r_state;
    logic [CW-1:0]      r_count;
    logic [LIMIT_W-1:0] r_cap_limit;
    t_mode              r_mode;
    t_value             r_key;
    logic               r_hit;
    logic [IW-1:0]      r_slot;
    logic               r_out_valid;
    t_status            r_status;
    logic [COUNT_W-1:0] r_out_count;

    logic [CAPACITY-1:0] cell_match;
    t_value              cell_value [CAPACITY];
    t_cell_ctl           cell_ctl   [CAPACITY];
    logic                red_hit;
    logic [IW-1:0]       red_slot;
    logic                upd_go;
    logic                full;
    logic [LW-1:0]       eff_limit;
    logic                do_load;
    logic                do_shift;
    t_status             n_status;
    logic [CW-1:0]       n_count;

    assign i_req.ready = (r_state == S_IDLE);
    assign upd_go      = (r_state == S_UPD) && (!r_out_valid || o_rsp.ready);

    // Saturate the limit at the cell count
    assign eff_limit = (LW'(r_cap_limit) > LW'(CAPACITY)) ? LW'(CAPACITY) : LW'(r_cap_limit);
    assign full      = LW'(r_count) >= eff_limit;

    // Decide the outcome of the request
    always_comb begin
        do_load  = 1'b0;
        do_shift = 1'b0;
        n_count  = r_count;
        case (r_mode)
            MODE_INSERT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else if (r_hit) begin
                    n_status = ST_PRESENT;
                end else begin
                    n_status = ST_INSERTED;
                    do_load  = 1'b1;
                    n_count  = r_count + CW'(1);
                end
            end
            MODE_REMOVE: begin
                if (r_hit) begin
                    n_status = ST_REMOVED;
                    do_shift = 1'b1;
                    n_count  = r_count - CW'(1);
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            default: begin
                n_status = r_hit ? ST_MEMBER : ST_NOT_MEMBER;
            end
        endcase
    end

    // Row of cells; cells from the removed slot upward take their upper neighbor's value on a remove
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic   valid_i;
        t_value next_i;

        assign valid_i = CW'(i) < r_count;
        assign cell_ctl[i].load  = upd_go && do_load && (CW'(i) == r_count);
        assign cell_ctl[i].shift = upd_go && do_shift && (IW'(i) >= r_slot);

        if (i == CAPACITY - 1) begin : g_last
            assign next_i = cell_value[i];
        end else begin : g_mid
            assign next_i = cell_value[i+1];
        end

        bss_cell u_cell (
            .i_clk        (i_clk),
            .i_key        (r_key),
            .i_cmp_en     (r_state == S_CMP),
            .i_valid      (valid_i),
            .i_ctl        (cell_ctl[i]),
            .i_next_value (next_i),
            .o_value      (cell_value[i]),
            .o_match      (cell_match[i])
        );
    end

    bss_reduce #(
        .CAPACITY (CAPACITY)
    ) u_reduce (
        .i_match (cell_match),
        .o_hit   (red_hit),
        .o_slot  (red_slot)
    );

    // Capture the request beat and the reduced match
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_mode <= i_req.mode;
            r_key  <= t_value'(i_req.element_value);
        end
        if (r_state == S_RED) begin
            r_hit  <= red_hit;
            r_slot <= red_slot;
        end
        if (upd_go) begin
            r_status    <= n_status;
            r_out_count <= COUNT_W'(n_count);
        end
    end

    // Sequence the request, hold the count and the limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cap_limit <= LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cap_limit <= i_cfg_wr_data;
            end
            // Raise the result on update, drop it once taken
            if (upd_go) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_RED;
                end
                S_RED: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (upd_go) begin
                        r_state <= S_IDLE;
                        r_count <= n_count;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_status;
    assign o_rsp.element_count = r_out_count;

    // Count never passes the number of cells
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("element count above capacity");

    // Live entries are distinct, so at most one cell matches
    a_single_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RED) |-> $onehot0(cell_match))
        else $error("more than one cell matched the key");

    // An insert grows the set by exactly one
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (upd_go && n_status == ST_INSERTED) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not advance the count");

    // A result beat appears only out of the update stage
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_UPD))
        else $error("result raised outside the update stage");

endmodule

/* rtl/bss_cell.sv */
`timescale 1ns / 1ps
// One storage cell of the set: holds a value, compares it with the key and
// takes either the key or its upper neighbor's value. Depends on bss_pkg.
module bss_cell
    import bss_pkg::*;
(
    input  logic      i_clk,
    input  t_value    i_key,
    input  logic      i_cmp_en,
    input  logic      i_valid,
    input  t_cell_ctl i_ctl,
    input  t_value    i_next_value,
    output t_value    o_value,
    output logic      o_match
);

    t_value r_value;
    logic   r_match;

    // Load, shift down or hold the stored value
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_value <= i_key;
        end else if (i_ctl.shift) begin
            r_value <= i_next_value;
        end
    end

    // Register the compare result for the reduction stage
    always_ff @(posedge i_clk) begin
        if (i_cmp_en) begin
            r_match <= i_valid && (r_value == i_key);
        end
    end

    assign o_value = r_value;
    assign o_match = r_match;

endmodule

/* rtl/bss_reduce.sv */
`timescale 1ns / 1ps
// Reduces the cells' match bits to a hit flag and the index of the matching
// cell. Entries are distinct, so at most one bit is set. Depends on bss_pkg.
module bss_reduce
    import bss_pkg::*;
#(
    parameter int unsigned CAPACITY = 64
) (
    input  logic [CAPACITY-1:0]         i_match,
    output logic                        o_hit,
    output logic [$clog2(CAPACITY)-1:0] o_slot
);

    localparam int unsigned IW = $clog2(CAPACITY);

    // OR together the indexes of set bits; one-hot input makes this exact
    always_comb begin
        o_slot = '0;
        for (int unsigned i = 0; i < CAPACITY; i++) begin
            o_slot = o_slot | (i_match[i] ? IW'(i) : '0);
        end
    end

    assign o_hit = |i_match;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for bounded_set_store: random and directed requests
// checked against a local set model.
// Depends on bss_pkg and the bss_req_if / bss_rsp_if interfaces from the RTL.
module testbench
    import bss_pkg::*;
();

    localparam int unsigned SET_DEPTH    = 64;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned LONG_HOLD    = 400;
    localparam int unsigned MIXED_ITEMS  = 55;
    localparam int unsigned NUM_PHASES   = 9;
    localparam t_mode       MODE_SPARE   = 2'd3;

    typedef struct {
        t_mode  mode;
        t_value value;
    } t_request;

    typedef struct {
        t_status    status;
        logic [6:0] count;
    } t_outcome;

    // Limits per random phase: extremes, saturation above depth, zero, lowered below count
    localparam logic [6:0] PHASE_LIMITS [NUM_PHASES] = '{
        7'd64, 7'd1, 7'd127, 7'd0, 7'd2, 7'd65, 7'd33, 7'd64, 7'd3
    };

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [6:0] cfg_wr_data;

    bss_req_if req_if ();
    bss_rsp_if rsp_if ();

    bounded_set_store #(
        .CAPACITY (SET_DEPTH)
    ) u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_req         (req_if.sink),
        .o_rsp         (rsp_if.source),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    // Set model state
    t_value     set_vals [SET_DEPTH];
    int         set_count;
    logic [6:0] set_limit;

    t_request pending_requests [$];
    t_outcome expected_outcomes [$];

    int       mismatch_count;
    int       requests_sent;
    int       results_seen;
    int       status_tally [8];
    int       hold_requests;
    int       holds_started;
    int       send_gap;
    int       stall_left;
    bit       idle_on;
    t_request next_req;
    t_outcome want;
    t_value   phase_values [$];

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Apply one request to the set model and return the result it must produce
    function automatic t_outcome apply_request(input t_mode mode, input t_value value);
        t_outcome res;
        int       slot;
        int       lim;
        slot = set_count;
        for (int i = set_count - 1; i >= 0; i--) begin
            if (set_vals[i] == value) slot = i;
        end
        lim = (set_limit > SET_DEPTH) ? SET_DEPTH : set_limit;
        case (mode)
            MODE_INSERT: begin
                if (set_count >= lim) begin
                    res.status = ST_FULL;
                end else if (slot < set_count) begin
                    res.status = ST_PRESENT;
                end else begin
                    set_vals[set_count] = value;
                    set_count++;
                    res.status = ST_INSERTED;
                end
            end
            MODE_REMOVE: begin
                if (slot < set_count) begin
                    for (int j = slot; j + 1 < set_count; j++) set_vals[j] = set_vals[j + 1];
                    set_count--;
                    res.status = ST_REMOVED;
                end else begin
                    res.status = ST_NOT_FOUND;
                end
            end
            default: begin
                res.status = (slot < set_count) ? ST_MEMBER : ST_NOT_MEMBER;
            end
        endcase
        res.count = 7'(set_count);
        return res;
    endfunction

    task automatic log_mismatch(input string what, input int got, input int exp_val);
        if (mismatch_count < 20)
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, exp_val);
        mismatch_count++;
    endtask

    task automatic queue_request(input t_mode mode, input t_value value);
        t_request r;
        r.mode  = mode;
        r.value = value;
        pending_requests.push_back(r);
    endtask

    // Hold until every request is sent and answered, then let the block settle;
    // sample just after the edge so the driver's updates have landed
    task automatic wait_idle();
        do begin
            @(posedge clk);
            #1;
        end while (pending_requests.size() != 0 || req_if.valid
                   || expected_outcomes.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [6:0] lim);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= lim;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        set_limit   = lim;
    endtask

    // Request driver: predict on each accepted beat, then offer the next item after a random gap while idles are on
    always @(posedge clk) begin
        if (!rst_n) begin
            req_if.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                expected_outcomes.push_back(apply_request(req_if.mode, req_if.element_value));
                requests_sent++;
            end
            if (!req_if.valid || req_if.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    req_if.valid <= 1'b0;
                end else if (pending_requests.size() != 0) begin
                    next_req = pending_requests.pop_front();
                    req_if.valid         <= 1'b1;
                    req_if.mode          <= next_req.mode;
                    req_if.element_value <= next_req.value;
                    send_gap = idle_on ? pick_gap() : 0;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result ready: long hold on request, random stalls otherwise while idles are on
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_if.ready <= 1'b0;
            stall_left = 0;
        end else if (holds_started != hold_requests) begin
            holds_started++;
            stall_left = LONG_HOLD;
            rsp_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 99) < 30) begin
            stall_left = pick_gap();
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    // Result monitor: compare each beat with the oldest prediction
    always @(posedge clk) begin
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            results_seen++;
            status_tally[rsp_if.status]++;
            if (expected_outcomes.size() == 0) begin
                log_mismatch("unexpected result, status", rsp_if.status, 0);
            end else begin
                want = expected_outcomes.pop_front();
                if (rsp_if.status !== want.status)
                    log_mismatch("status", rsp_if.status, want.status);
                if (rsp_if.element_count !== want.count)
                    log_mismatch("element_count", rsp_if.element_count, want.count);
            end
        end
    end

    // Stimulus and run control
    initial begin
        int     span;
        int     r;
        t_mode  m;
        t_value v;
        rst_n                = 1'b0;
        cfg_wr_en            = 1'b0;
        cfg_wr_data          = '0;
        req_if.valid         = 1'b0;
        req_if.mode          = MODE_INSERT;
        req_if.element_value = '0;
        rsp_if.ready         = 1'b0;
        idle_on              = 1'b1;
        set_count            = 0;
        set_limit            = LIMIT_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, every status but full, gap closing, unused mode, empty set
        queue_request(MODE_INSERT, 32'h7FFF_FFFF);
        queue_request(MODE_INSERT, 32'h8000_0000);
        queue_request(MODE_INSERT, 32'h0000_0000);
        queue_request(MODE_INSERT, 32'hFFFF_FFFF);
        queue_request(MODE_INSERT, 32'h7FFF_FFFF);
        queue_request(MODE_QUERY,  32'h8000_0000);
        queue_request(MODE_QUERY,  32'h0000_0005);
        queue_request(MODE_SPARE,  32'hFFFF_FFFF);
        queue_request(MODE_SPARE,  32'h0000_0007);
        queue_request(MODE_REMOVE, 32'h0000_0000);
        queue_request(MODE_QUERY,  32'hFFFF_FFFF);
        queue_request(MODE_REMOVE, 32'h0000_3039);
        queue_request(MODE_REMOVE, 32'h7FFF_FFFF);
        queue_request(MODE_REMOVE, 32'hFFFF_FFFF);
        queue_request(MODE_REMOVE, 32'h8000_0000);
        queue_request(MODE_REMOVE, 32'h0000_0000);
        queue_request(MODE_QUERY,  32'h0000_0000);
        wait_idle();

        // Small limit: full set, full with a duplicate value
        write_limit(7'd2);
        queue_request(MODE_INSERT, 32'd10);
        queue_request(MODE_INSERT, 32'd20);
        queue_request(MODE_INSERT, 32'd30);
        queue_request(MODE_INSERT, 32'd10);
        queue_request(MODE_REMOVE, 32'd10);
        queue_request(MODE_INSERT, 32'd30);
        wait_idle();

        // Limit of zero, below the count: held entries stay usable
        write_limit(7'd0);
        queue_request(MODE_INSERT, 32'd40);
        queue_request(MODE_QUERY,  32'd20);
        queue_request(MODE_REMOVE, 32'd20);
        queue_request(MODE_INSERT, 32'd50);
        wait_idle();

        // Random phases: fill with distinct values, then a mixed run over the same pool
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_limit(PHASE_LIMITS[p]);
            idle_on = (p % 3) != 1;
            if (p == 2) hold_requests++;
            span = ((PHASE_LIMITS[p] > SET_DEPTH) ? SET_DEPTH : PHASE_LIMITS[p]) + 4;
            phase_values.delete();
            repeat (span) phase_values.push_back($urandom);
            foreach (phase_values[k]) queue_request(MODE_INSERT, phase_values[k]);
            repeat (MIXED_ITEMS) begin
                v = ($urandom_range(0, 99) < 85)
                    ? phase_values[$urandom_range(0, span - 1)] : t_value'($urandom);
                r = $urandom_range(0, 99);
                if (r < 35)      m = MODE_INSERT;
                else if (r < 70) m = MODE_REMOVE;
                else if (r < 96) m = MODE_QUERY;
                else             m = MODE_SPARE;
                queue_request(m, v);
            end
            // Sender pauses here until every result is back
            wait_idle();
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (expected_outcomes.size() != 0)
            log_mismatch("results still outstanding", expected_outcomes.size(), 0);
        $display("Run covered %0d requests and %0d results over %0d limit settings",
                 requests_sent, results_seen, NUM_PHASES + 3);
        $display("Status mix: ins %0d dup %0d full %0d rem %0d miss %0d mem %0d nonmem %0d",
                 status_tally[ST_INSERTED], status_tally[ST_PRESENT], status_tally[ST_FULL],
                 status_tally[ST_REMOVED], status_tally[ST_NOT_FOUND], status_tally[ST_MEMBER],
                 status_tally[ST_NOT_MEMBER]);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("Timeout with %0d results outstanding", expected_outcomes.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
